>>> rtl/uble_pkg.sv
package uble_pkg;

  // Line geometry: bytes per line, 3-byte groups per line.
  localparam int unsigned LINE_BYTES = 45;
  localparam int unsigned LINE_WORDS = (LINE_BYTES + 2) / 3;
  localparam int unsigned WORD_W     = $clog2(LINE_WORDS);
  localparam int unsigned FILL_W     = $clog2(LINE_BYTES + 1);

  // Configuration register indexes.
  localparam logic REG_BASE64_MODE = 1'b0;
  localparam logic REG_MAX_LINES   = 1'b1;

  // Output character select codes.
  localparam logic [1:0] SEL_LEN  = 2'd0;
  localparam logic [1:0] SEL_DATA = 2'd1;
  localparam logic [1:0] SEL_NL   = 2'd2;
  localparam logic [1:0] SEL_ENDC = 2'd3;

  typedef struct packed {
    logic       wr;         // store the input byte
    logic       grp_inc;    // advance to the next 3-byte group
    logic       chr_inc;    // advance to the next symbol of the group
    logic       line_done;  // close the line, update the line count
    logic [1:0] sel;        // which character drives the output
  } ctrl_cmd_t;

  typedef struct packed {
    logic ends_line;   // the offered byte completes a line
    logic last_grp;    // current group is the last of the line
    logic last_chr;    // current symbol is the fourth of its group
    logic b64;         // base64 mode
    logic add_marker;  // end marker follows this line
    logic part_end;    // this line closes a part
  } dp_stat_t;

endpackage

>>> rtl/uble_datapath.sv
module uble_datapath
  import uble_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  input  logic        final_part_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  output logic [7:0]  out_char_o
);

  function automatic logic [7:0] enc_sym(input logic [5:0] v, input logic b64);
    logic [7:0] r;
    r = 8'h00;
    if (b64) begin
      if (v < 6'd26)      r = 8'h41 + {2'b00, v};
      else if (v < 6'd52) r = 8'h61 + {2'b00, v} - 8'd26;
      else if (v < 6'd62) r = 8'h30 + {2'b00, v} - 8'd52;
      else if (v == 6'd62) r = 8'h2B;
      else                r = 8'h2F;
    end else begin
      r = (v == 6'd0) ? 8'h60 : (8'h20 + {2'b00, v});
    end
    return r;
  endfunction

  logic              mode_q;
  logic [15:0]       max_q;
  logic [23:0]       mem [LINE_WORDS];
  logic [23:0]       rdata_q;
  logic [WORD_W-1:0] word_q, word_d;
  logic [1:0]        lane_q, lane_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WORD_W-1:0] grp_q, grp_d;
  logic [1:0]        chr_q, chr_d;
  logic [15:0]       line_cnt_q, line_cnt_d;
  logic              eoi_q, eoi_d, fin_q, fin_d;

  logic [15:0] line_inc;
  logic        ends_line, last_grp, has1, has2, part_end;
  logic [7:0]  b0, b1, b2, pad, data_char;
  logic [FILL_W-1:0] len;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      max_q  <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE64_MODE: mode_q <= cfg_data_i[0];
        REG_MAX_LINES:   max_q  <= cfg_data_i;
        default:         mode_q <= mode_q;
      endcase
    end
  end

  // Line store: one 3-byte group per word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[word_q][{lane_q, 3'b000} +: 8] <= data_byte_i;
    end
    rdata_q <= mem[grp_q];
  end

  assign ends_line = (fill_q == FILL_W'(LINE_BYTES - 1)) || end_of_input_i;
  assign line_inc  = line_cnt_q + 16'd1;
  assign part_end  = eoi_q || (line_inc >= max_q);
  assign last_grp  = (grp_q == word_q);

  always_comb begin
    word_d     = word_q;
    lane_d     = lane_q;
    fill_d     = fill_q;
    grp_d      = grp_q;
    chr_d      = chr_q;
    line_cnt_d = line_cnt_q;
    eoi_d      = eoi_q;
    fin_d      = fin_q;
    if (cmd_i.wr) begin
      if (ends_line) begin
        // hold the write position: it marks the last group of the line
        grp_d = '0;
        chr_d = '0;
        eoi_d = end_of_input_i;
        fin_d = final_part_i;
      end else begin
        fill_d = fill_q + 1'b1;
        if (lane_q == 2'd2) begin
          lane_d = 2'd0;
          word_d = word_q + 1'b1;
        end else begin
          lane_d = lane_q + 1'b1;
        end
      end
    end
    if (cmd_i.grp_inc) begin
      grp_d = grp_q + 1'b1;
      chr_d = '0;
    end
    if (cmd_i.chr_inc) begin
      chr_d = chr_q + 1'b1;
    end
    if (cmd_i.line_done) begin
      fill_d     = '0;
      word_d     = '0;
      lane_d     = 2'd0;
      line_cnt_d = part_end ? 16'd0 : line_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q     <= '0;
      lane_q     <= 2'd0;
      fill_q     <= '0;
      grp_q      <= '0;
      chr_q      <= 2'd0;
      line_cnt_q <= 16'd0;
      eoi_q      <= 1'b0;
      fin_q      <= 1'b0;
    end else begin
      word_q     <= word_d;
      lane_q     <= lane_d;
      fill_q     <= fill_d;
      grp_q      <= grp_d;
      chr_q      <= chr_d;
      line_cnt_q <= line_cnt_d;
      eoi_q      <= eoi_d;
      fin_q      <= fin_d;
    end
  end

  // Symbols of the current group; missing bytes read as zero.
  assign has1 = !last_grp || (lane_q != 2'd0);
  assign has2 = !last_grp || (lane_q == 2'd2);
  assign b0   = rdata_q[7:0];
  assign b1   = has1 ? rdata_q[15:8] : 8'h00;
  assign b2   = has2 ? rdata_q[23:16] : 8'h00;
  assign pad  = mode_q ? 8'h3D : 8'h60;
  assign len  = fill_q + 1'b1;

  always_comb begin
    unique case (chr_q)
      2'd0: data_char = enc_sym(b0[7:2], mode_q);
      2'd1: data_char = enc_sym({b0[1:0], b1[7:4]}, mode_q);
      2'd2: data_char = has1 ? enc_sym({b1[3:0], b2[7:6]}, mode_q) : pad;
      default: data_char = has2 ? enc_sym(b2[5:0], mode_q) : pad;
    endcase
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_LEN:  out_char_o = enc_sym(6'(len), mode_q);
      SEL_DATA: out_char_o = data_char;
      SEL_NL:   out_char_o = 8'h0A;
      default:  out_char_o = 8'h60;
    endcase
  end

  assign stat_o.ends_line  = ends_line;
  assign stat_o.last_grp   = last_grp;
  assign stat_o.last_chr   = (chr_q == 2'd3);
  assign stat_o.b64        = mode_q;
  assign stat_o.add_marker = eoi_q && fin_q && !mode_q;
  assign stat_o.part_end   = part_end;

endmodule

>>> rtl/uble_ctrl.sv
module uble_ctrl
  import uble_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic      last_of_run_o,
  output logic      part_done_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LEN   = 3'd1;
  localparam logic [2:0] ST_FETCH = 3'd2;
  localparam logic [2:0] ST_CHAR  = 3'd3;
  localparam logic [2:0] ST_NL    = 3'd4;
  localparam logic [2:0] ST_ENDC  = 3'd5;
  localparam logic [2:0] ST_ENDN  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_DATA;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    last_of_run_o = 1'b0;
    part_done_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.wr = 1'b1;
          if (stat_i.ends_line) begin
            state_d = stat_i.b64 ? ST_FETCH : ST_LEN;
          end
        end
      end
      ST_LEN: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_LEN;
        if (out_ready_i) state_d = ST_CHAR;
      end
      ST_FETCH: begin
        state_d = ST_CHAR;
      end
      ST_CHAR: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (!stat_i.last_chr) begin
            cmd_o.chr_inc = 1'b1;
          end else if (stat_i.last_grp) begin
            state_d = ST_NL;
          end else begin
            cmd_o.grp_inc = 1'b1;
            state_d       = ST_FETCH;
          end
        end
      end
      ST_NL: begin
        out_valid_o   = 1'b1;
        cmd_o.sel     = SEL_NL;
        last_of_run_o = !stat_i.add_marker;
        part_done_o   = stat_i.part_end && !stat_i.add_marker;
        if (out_ready_i) begin
          cmd_o.line_done = 1'b1;
          state_d = stat_i.add_marker ? ST_ENDC : ST_IDLE;
        end
      end
      ST_ENDC: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_ENDC;
        if (out_ready_i) state_d = ST_ENDN;
      end
      ST_ENDN: begin
        out_valid_o   = 1'b1;
        cmd_o.sel     = SEL_NL;
        last_of_run_o = 1'b1;
        part_done_o   = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/uuencode_base64_line_encoder.sv
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+------------------------------------------
// in      | input     | in_valid_i/in_ready_o | data_byte_i, end_of_input_i, final_part_i
// out     | output    | out_valid_o/out_ready_i | out_char_o, last_of_run_o, part_done_o
// cfg     | input     | cfg_we_i (no wait)   | cfg_idx_i, cfg_data_i
//
// Bytes that do not close a line are accepted back to back. A line of n bytes then
// streams out at one character per cycle while out_ready_i is high, with a fetch
// state before each 3-byte group to read the group word from the line store
// (the first fetch hides under the length character in uuencode mode).
// Reset clears counters, state and configuration; the line store is not cleared.
// The input side stalls while a line is being emitted; out_ready_i low holds
// the current character.
module uuencode_base64_line_encoder
  import uble_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  input  logic        final_part_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_of_run_o,
  output logic        part_done_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer: accepts bytes, then walks the line store group by group.
  uble_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_of_run_o (last_of_run_o),
    .part_done_o   (part_done_o),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Line store, counters, configuration and the symbol encoder.
  uble_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .final_part_i   (final_part_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_char_o     (out_char_o)
  );

  // Input and output never overlap: a line is emitted while the input stalls.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while a line is being emitted");

  // The closing character of any run is a newline.
  a_last_is_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (out_char_o == 8'h0A))
    else $error("run closed by a character other than newline");

  // A part closes only on the last character of a run.
  a_part_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && part_done_o) |-> last_of_run_o)
    else $error("part closed before the end of the run");

  // After the last character of a run the block takes input again.
  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_run_o) |=> in_ready_o)
    else $error("input not reopened after a run");

endmodule

>>> test/uble_line_checker.sv
module uble_line_checker
  import uble_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  input  logic        final_part_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_i,
  input  logic        last_of_run_i,
  input  logic        part_done_i,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       part_end;
  } enc_char_t;

  localparam logic [7:0] NEWLINE  = 8'h0A;
  localparam logic [7:0] B64_PAD  = 8'h3D;
  localparam logic [7:0] UU_ZERO  = 8'h60;
  localparam logic [7:0] B64_PLUS = 8'h2B;
  localparam logic [7:0] B64_DIV  = 8'h2F;

  enc_char_t   expected_chars[$];
  enc_char_t   want;
  logic        bad;
  logic [7:0]  line_bytes [LINE_BYTES];
  int unsigned fill;
  logic [15:0] lines_in_part;
  logic        b64_mode;
  logic [15:0] max_lines;

  function automatic logic [7:0] symbol(logic b64, logic [5:0] v);
    if (!b64) return (v == 6'd0) ? UU_ZERO : 8'h20 + {2'b00, v};
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    if (v < 6'd52) return 8'h47 + {2'b00, v};
    if (v < 6'd62) return {2'b00, v} - 8'd4;
    return (v == 6'd62) ? B64_PLUS : B64_DIV;
  endfunction

  // Encode the buffered line and queue its characters.
  task automatic encode_line(logic eoi, logic fin);
    logic [7:0]  chars [64];
    int          n;
    int          j;
    int unsigned i;
    int unsigned cnt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  pad;
    logic        part_end;
    n = 0;
    pad = b64_mode ? B64_PAD : UU_ZERO;
    if (!b64_mode) begin
      chars[n] = symbol(1'b0, 6'(fill));
      n = n + 1;
    end
    for (i = 0; i < fill; i += 3) begin
      cnt = (fill - i > 3) ? 3 : fill - i;
      b0 = line_bytes[i];
      b1 = (cnt > 1) ? line_bytes[i + 1] : 8'h00;
      b2 = (cnt > 2) ? line_bytes[i + 2] : 8'h00;
      chars[n]     = symbol(b64_mode, b0[7:2]);
      chars[n + 1] = symbol(b64_mode, {b0[1:0], b1[7:4]});
      chars[n + 2] = (cnt > 1) ? symbol(b64_mode, {b1[3:0], b2[7:6]}) : pad;
      chars[n + 3] = (cnt > 2) ? symbol(b64_mode, b2[5:0]) : pad;
      n = n + 4;
    end
    chars[n] = NEWLINE;
    n = n + 1;
    fill = 0;

    lines_in_part = lines_in_part + 16'd1;
    part_end = eoi || (lines_in_part >= max_lines);
    if (part_end) lines_in_part = '0;

    if (eoi && fin && !b64_mode) begin
      chars[n]     = UU_ZERO;
      chars[n + 1] = NEWLINE;
      n = n + 2;
    end

    for (j = 0; j < n; j++) begin
      expected_chars.push_back(enc_char_t'{chars[j], j == n - 1, part_end && (j == n - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      fill          = 0;
      lines_in_part = '0;
      b64_mode      = 1'b0;
      max_lines     = 16'hFFFF;
      err_count_o   = 0;
      checked_o     = 0;
    end else begin
      // Compare first: a transaction never answers a byte taken at the same edge.
      if (out_valid_i && out_ready_i) begin
        checked_o = checked_o + 1;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected output char %h (last %b part %b)",
                   $time, out_char_i, last_of_run_i, part_done_i);
          err_count_o = err_count_o + 1;
        end else begin
          want = expected_chars.pop_front();
          bad  = 1'b0;
          if (want.ch !== out_char_i) begin
            $display("%0t: out_char expected %h got %h", $time, want.ch, out_char_i);
            bad = 1'b1;
          end
          if (want.last !== last_of_run_i) begin
            $display("%0t: last_of_run expected %b got %b", $time, want.last, last_of_run_i);
            bad = 1'b1;
          end
          if (want.part_end !== part_done_i) begin
            $display("%0t: part_done expected %b got %b", $time, want.part_end, part_done_i);
            bad = 1'b1;
          end
          if (bad) err_count_o = err_count_o + 1;
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (fill < LINE_BYTES) line_bytes[fill] = data_byte_i;
        fill = fill + 1;
        if (fill >= LINE_BYTES || end_of_input_i) encode_line(end_of_input_i, final_part_i);
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE64_MODE: b64_mode  = cfg_data_i[0];
          REG_MAX_LINES:   max_lines = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

>>> test/uuencode_base64_line_encoder_tb.sv
module uuencode_base64_line_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uble_pkg::*;

  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 6;
  // Leave margin after a drain, before config writes.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 40;

  // Every block input starts at a known value.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = REG_BASE64_MODE;
  logic [15:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic [7:0]  data_byte_i    = '0;
  logic        end_of_input_i = 1'b0;
  logic        final_part_i   = 1'b0;
  logic        out_ready_i    = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_char_o;
  logic        last_of_run_o;
  logic        part_done_o;

  int unsigned err_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned gap_pct   = 0;  // chance in 100 of an idle cycle before a byte
  int unsigned stall_pct = 0;  // chance in 100 of out_ready_i low in a cycle
  int unsigned items_sent = 0;

  always #10 clk_i = ~clk_i;

  uuencode_base64_line_encoder DUT (.*);

  uble_line_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .final_part_i   (final_part_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_i     (out_char_o),
    .last_of_run_i  (last_of_run_o),
    .part_done_i    (part_done_o),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // Receiver: stall at random according to the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  // Offer one byte; hold valid and payload until the transaction completes.
  // Return at the falling edge after acceptance with valid still high, so a
  // back-to-back byte only rewrites the payload.
  task automatic send_byte(logic [7:0] b, logic eoi, logic fin);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= eoi;
    final_part_i   <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Send one line's worth of bytes. Most lines are well formed: a full line,
  // or a short run closed by end of input. The rest is noise: a partial line
  // with stray end-of-input bits, which may leave bytes open for the next phase.
  task automatic send_line(logic force_full);
    int unsigned len;
    int unsigned j;
    int unsigned kind;
    logic        eoi_end;
    logic        eoi;
    logic        fin;
    kind = force_full ? 0 : $urandom_range(99);
    if (kind < 20) begin
      len     = LINE_BYTES;
      eoi_end = force_full ? 1'b0 : 1'($urandom_range(1));
    end else if (kind < 85) begin
      len     = $urandom_range(1, 12);
      eoi_end = 1'b1;
    end else begin
      len     = $urandom_range(1, LINE_BYTES - 1);
      eoi_end = 1'b0;
    end
    for (j = 0; j < len; j++) begin
      if (j == len - 1) eoi = eoi_end;
      else eoi = (kind >= 85) && ($urandom_range(9) == 0);
      // final_part without end of input must be ignored, so drive it anyway.
      fin = eoi ? 1'($urandom_range(1)) : ($urandom_range(3) == 0);
      send_byte(8'($urandom_range(255)), eoi, fin);
    end
  endtask

  // Write one register; the enable is high for exactly one rising edge.
  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every predicted character, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    int unsigned start;
    logic        mode;
    logic [15:0] limit;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: uuencode, lines of one, two and three bytes, all-zero and
    // all-one bytes, final_part without end of input, then the end marker.
    write_reg(REG_BASE64_MODE, 16'd0);
    write_reg(REG_MAX_LINES, 16'hFFFF);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'h0F, 1'b1, 1'b1);
    drain();

    // Directed: base64 with '=' padding; no end marker on the final part.
    write_reg(REG_BASE64_MODE, 16'd1);
    write_reg(REG_MAX_LINES, 16'd1);
    send_byte(8'hFB, 1'b1, 1'b1);
    send_byte(8'hEF, 1'b0, 1'b0);
    send_byte(8'hBE, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b1);

    // Directed: switch mode with a line half filled; emission mode applies.
    send_byte(8'h12, 1'b0, 1'b0);
    drain();
    write_reg(REG_BASE64_MODE, 16'd0);
    send_byte(8'h34, 1'b1, 1'b1);
    drain();

    // Random phases: each sets both registers and an idling pattern.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin mode = 1'b0; limit = 16'hFFFF; end
        1:       begin mode = 1'b1; limit = 16'd1;    end
        2:       begin mode = 1'b0; limit = 16'd2;    end
        3:       begin mode = 1'b0; limit = 16'd0;    end
        4:       begin mode = 1'b1; limit = 16'hFFFF; end
        default: begin mode = 1'b0; limit = 16'd1;    end
      endcase
      write_reg(REG_BASE64_MODE, {15'd0, mode});
      write_reg(REG_MAX_LINES, limit);
      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 61; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 61; end
        default: begin gap_pct = 17; stall_pct = 17; end
      endcase
      if (limit == 16'd2) begin
        // Close any open line, then run a full line that leaves the part open.
        send_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        send_line(1'b1);
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_line(1'b0);
      drain();
    end

    gap_pct   = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Sent %0d bytes over both alphabets, line limits 0, 1, 2 and 65535,", items_sent);
    $display("under sender gaps and receiver stalls; %0d characters compared.", checked);
    if (err_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
